[rtl/fppe_pkg.sv]
// Package for the framed parameter packet engine: codes, microcode types,
// the microprogram and the default parameter table.
// Depends on nothing; used by the engine core.
`default_nettype none

package fppe_pkg;

    localparam int LEN_W     = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_OP_WRITE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OP_READ  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OP_RESET = 2'd2;

    localparam logic [7:0] OP_WRITE_RST = 8'd3;
    localparam logic [7:0] OP_READ_RST  = 8'd2;
    localparam logic [7:0] OP_RESET_RST = 8'd6;

    localparam logic [7:0] HDR_BYTE = 8'hFF;

    typedef enum logic [4:0] {
        S_FILL    = 5'd0,
        S_HUNT1   = 5'd1,
        S_HUNT2   = 5'd2,
        S_ID      = 5'd3,
        S_OPC     = 5'd4,
        S_LEN     = 5'd5,
        S_LEN0    = 5'd6,
        S_PAY     = 5'd7,
        S_PAYN    = 5'd8,
        S_CHECK   = 5'd9,
        S_DISP_W  = 5'd10,
        S_DISP_R  = 5'd11,
        S_DISP_X  = 5'd12,
        S_GOHUNT  = 5'd13,
        S_WTEST   = 5'd14,
        S_WIDX    = 5'd15,
        S_WVAL    = 5'd16,
        S_RH1     = 5'd17,
        S_RH2     = 5'd18,
        S_RID     = 5'd19,
        S_ROP     = 5'd20,
        S_RLEN    = 5'd21,
        S_RTEST   = 5'd22,
        S_RIDX    = 5'd23,
        S_REIDX   = 5'd24,
        S_REVAL   = 5'd25,
        S_RSUM    = 5'd26
    } t_step;

    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_FILL,
        ACT_LD_ID,
        ACT_LD_OP,
        ACT_LD_LEN,
        ACT_ST_PAY,
        ACT_CLR_CNT,
        ACT_RD_INC,
        ACT_LD_IDX_INC,
        ACT_WR_TBL,
        ACT_CLR_SUM,
        ACT_LD_IDX,
        ACT_ADD_IDX,
        ACT_ADD_VAL_INC
    } t_act;

    typedef enum logic [3:0] {
        CND_NEVER,
        CND_ALWAYS,
        CND_CNT_NOT_LAST,
        CND_NOT_FF,
        CND_IS_FF,
        CND_LEN_BAD,
        CND_LEN_ZERO,
        CND_CNT_LT_LEN,
        CND_SUM_BAD,
        CND_OP_WR,
        CND_OP_RD,
        CND_OP_RST,
        CND_NO_PAIR,
        CND_CNT_GE_LEN
    } t_cond;

    typedef enum logic [2:0] {
        SRC_FF,
        SRC_ID,
        SRC_OPRD,
        SRC_LEN,
        SRC_IDX,
        SRC_VAL,
        SRC_SUM
    } t_src;

    typedef struct packed {
        logic  take_in;
        logic  emit;
        t_src  src;
        t_act  act;
        t_cond cond;
        t_step tgt;
    } t_uword;

    // A taken condition jumps to the target; otherwise the step counter advances.
    function automatic t_uword ucode(input t_step s);
        t_uword uw;
        case (s)
            S_FILL:   uw = '{1'b0, 1'b0, SRC_FF,   ACT_FILL,        CND_CNT_NOT_LAST, S_FILL};
            S_HUNT1:  uw = '{1'b1, 1'b0, SRC_FF,   ACT_NONE,        CND_NOT_FF,       S_HUNT1};
            S_HUNT2:  uw = '{1'b1, 1'b0, SRC_FF,   ACT_NONE,        CND_NOT_FF,       S_HUNT1};
            S_ID:     uw = '{1'b1, 1'b0, SRC_FF,   ACT_LD_ID,       CND_NEVER,        S_HUNT1};
            S_OPC:    uw = '{1'b1, 1'b0, SRC_FF,   ACT_LD_OP,       CND_NEVER,        S_HUNT1};
            S_LEN:    uw = '{1'b1, 1'b0, SRC_FF,   ACT_LD_LEN,      CND_LEN_BAD,      S_HUNT1};
            S_LEN0:   uw = '{1'b0, 1'b0, SRC_FF,   ACT_NONE,        CND_LEN_ZERO,     S_CHECK};
            S_PAY:    uw = '{1'b1, 1'b0, SRC_FF,   ACT_ST_PAY,      CND_IS_FF,        S_HUNT1};
            S_PAYN:   uw = '{1'b0, 1'b0, SRC_FF,   ACT_NONE,        CND_CNT_LT_LEN,   S_PAY};
            S_CHECK:  uw = '{1'b1, 1'b0, SRC_FF,   ACT_CLR_CNT,     CND_SUM_BAD,      S_HUNT1};
            S_DISP_W: uw = '{1'b0, 1'b0, SRC_FF,   ACT_NONE,        CND_OP_WR,        S_WTEST};
            S_DISP_R: uw = '{1'b0, 1'b0, SRC_FF,   ACT_NONE,        CND_OP_RD,        S_RH1};
            S_DISP_X: uw = '{1'b0, 1'b0, SRC_FF,   ACT_NONE,        CND_OP_RST,       S_FILL};
            S_GOHUNT: uw = '{1'b0, 1'b0, SRC_FF,   ACT_NONE,        CND_ALWAYS,       S_HUNT1};
            S_WTEST:  uw = '{1'b0, 1'b0, SRC_FF,   ACT_RD_INC,      CND_NO_PAIR,      S_HUNT1};
            S_WIDX:   uw = '{1'b0, 1'b0, SRC_FF,   ACT_LD_IDX_INC,  CND_NEVER,        S_HUNT1};
            S_WVAL:   uw = '{1'b0, 1'b0, SRC_FF,   ACT_WR_TBL,      CND_ALWAYS,       S_WTEST};
            S_RH1:    uw = '{1'b0, 1'b1, SRC_FF,   ACT_CLR_SUM,     CND_NEVER,        S_HUNT1};
            S_RH2:    uw = '{1'b0, 1'b1, SRC_FF,   ACT_NONE,        CND_NEVER,        S_HUNT1};
            S_RID:    uw = '{1'b0, 1'b1, SRC_ID,   ACT_NONE,        CND_NEVER,        S_HUNT1};
            S_ROP:    uw = '{1'b0, 1'b1, SRC_OPRD, ACT_NONE,        CND_NEVER,        S_HUNT1};
            S_RLEN:   uw = '{1'b0, 1'b1, SRC_LEN,  ACT_NONE,        CND_NEVER,        S_HUNT1};
            S_RTEST:  uw = '{1'b0, 1'b0, SRC_FF,   ACT_NONE,        CND_CNT_GE_LEN,   S_RSUM};
            S_RIDX:   uw = '{1'b0, 1'b0, SRC_FF,   ACT_LD_IDX,      CND_NEVER,        S_HUNT1};
            S_REIDX:  uw = '{1'b0, 1'b1, SRC_IDX,  ACT_ADD_IDX,     CND_NEVER,        S_HUNT1};
            S_REVAL:  uw = '{1'b0, 1'b1, SRC_VAL,  ACT_ADD_VAL_INC, CND_ALWAYS,       S_RTEST};
            S_RSUM:   uw = '{1'b0, 1'b1, SRC_SUM,  ACT_NONE,        CND_ALWAYS,       S_HUNT1};
            default:  uw = '{1'b0, 1'b0, SRC_FF,   ACT_NONE,        CND_ALWAYS,       S_HUNT1};
        endcase
        return uw;
    endfunction

    function automatic logic [7:0] default_val(input logic [7:0] idx);
        logic [7:0] v;
        case (idx)
            8'd0, 8'd1, 8'd2, 8'd4, 8'd5: v = 8'd127;
            8'd10:                        v = 8'd150;
            default:                      v = 8'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[rtl/framed_param_packet_engine_core.sv]
// Framed parameter packet engine: a microcoded sequencer that parses framed
// packets and serves writes, reads and table resets. Depends on fppe_pkg and fppe_ram.
// Header, id, opcode and length bytes are taken one per cycle while a byte is offered; each payload
// byte is followed by a step that takes none. After the closing byte, a write runs S_WTEST, S_WIDX
// and S_WVAL for each pair, a reset reruns the clearing pass, and a read emits 6 + 2*length bytes.
// Reset is synchronous; afterwards a clearing pass over all TABLE_ENTRIES entries loads the defaults
// while no received byte is taken.
`default_nettype none

module framed_param_packet_engine_core #(
    parameter int MAX_PAYLOAD   = 16,
    parameter int TABLE_ENTRIES = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_rx_valid,
    output logic                                o_rx_ready,
    input  wire logic [7:0]                     i_rx_byte,
    output logic                                o_tx_valid,
    input  wire logic                           i_tx_ready,
    output logic      [7:0]                     o_tx_byte,
    output logic                                o_tx_last,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [fppe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [7:0]                     i_cfg_data
);

    localparam int SA_W  = $clog2(MAX_PAYLOAD);
    localparam int TA_W  = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2((TABLE_ENTRIES > MAX_PAYLOAD + 2) ?
                                  TABLE_ENTRIES : MAX_PAYLOAD + 2);

    fppe_pkg::t_step  r_pc, n_pc;
    fppe_pkg::t_uword uw;

    logic [CNT_W-1:0]           r_cnt, n_cnt;
    logic [7:0]                 r_op_write, r_op_read, r_op_reset;
    logic [7:0]                 r_id, n_id;
    logic [7:0]                 r_op, n_op;
    logic [fppe_pkg::LEN_W-1:0] r_len, n_len;
    logic [7:0]                 r_sum, n_sum;
    logic [7:0]                 r_idx, n_idx;
    logic                       r_tx_valid, n_tx_valid;
    logic [7:0]                 r_tx_byte, n_tx_byte;
    logic                       r_tx_last, n_tx_last;

    logic            go, slot_free, cond_hit, idx_ok;
    logic [8:0]      cnt_x, len_x;
    logic [7:0]      st_rdata, tbl_rdata, tbl_val, tbl_wdata;
    logic            st_we, tbl_we;
    logic [TA_W-1:0] tbl_waddr, tbl_raddr;

    assign uw          = fppe_pkg::ucode(r_pc);
    assign slot_free   = !r_tx_valid || i_tx_ready;
    assign go          = (!uw.take_in || i_rx_valid) && (!uw.emit || slot_free);
    assign o_rx_ready  = uw.take_in;
    assign o_cfg_ready = 1'b1;
    assign o_tx_valid  = r_tx_valid;
    assign o_tx_byte   = r_tx_byte;
    assign o_tx_last   = r_tx_last;
    assign cnt_x       = 9'(r_cnt);
    assign len_x       = 9'(r_len);
    assign idx_ok      = r_idx < 8'(TABLE_ENTRIES);
    assign tbl_val     = idx_ok ? tbl_rdata : 8'd0;

    fppe_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (st_we),
        .i_waddr (r_cnt[SA_W-1:0]),
        .i_wdata (i_rx_byte),
        .i_raddr (r_cnt[SA_W-1:0]),
        .o_rdata (st_rdata)
    );

    fppe_ram #(
        .WIDTH (8),
        .DEPTH (TABLE_ENTRIES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (tbl_we),
        .i_waddr (tbl_waddr),
        .i_wdata (tbl_wdata),
        .i_raddr (tbl_raddr),
        .o_rdata (tbl_rdata)
    );

    always_comb begin
        case (uw.cond)
            fppe_pkg::CND_NEVER:        cond_hit = 1'b0;
            fppe_pkg::CND_ALWAYS:       cond_hit = 1'b1;
            fppe_pkg::CND_CNT_NOT_LAST: cond_hit = r_cnt != CNT_W'(TABLE_ENTRIES - 1);
            fppe_pkg::CND_NOT_FF:       cond_hit = i_rx_byte != fppe_pkg::HDR_BYTE;
            fppe_pkg::CND_IS_FF:        cond_hit = i_rx_byte == fppe_pkg::HDR_BYTE;
            fppe_pkg::CND_LEN_BAD:      cond_hit = i_rx_byte > 8'(MAX_PAYLOAD);
            fppe_pkg::CND_LEN_ZERO:     cond_hit = r_len == '0;
            fppe_pkg::CND_CNT_LT_LEN:   cond_hit = cnt_x < len_x;
            fppe_pkg::CND_SUM_BAD:      cond_hit = i_rx_byte != ~r_sum;
            fppe_pkg::CND_OP_WR:        cond_hit = r_op == r_op_write;
            fppe_pkg::CND_OP_RD:        cond_hit = r_op == r_op_read;
            fppe_pkg::CND_OP_RST:       cond_hit = r_op == r_op_reset;
            fppe_pkg::CND_NO_PAIR:      cond_hit = (cnt_x + 9'd1) >= len_x;
            fppe_pkg::CND_CNT_GE_LEN:   cond_hit = cnt_x >= len_x;
            default:                    cond_hit = 1'b0;
        endcase
    end

    always_comb begin
        n_pc       = r_pc;
        n_cnt      = r_cnt;
        n_id       = r_id;
        n_op       = r_op;
        n_len      = r_len;
        n_sum      = r_sum;
        n_idx      = r_idx;
        n_tx_valid = r_tx_valid && !i_tx_ready;
        n_tx_byte  = r_tx_byte;
        n_tx_last  = r_tx_last;
        st_we      = 1'b0;
        tbl_we     = 1'b0;
        tbl_waddr  = r_idx[TA_W-1:0];
        tbl_wdata  = st_rdata;
        tbl_raddr  = r_idx[TA_W-1:0];
        if (uw.act == fppe_pkg::ACT_LD_IDX) begin
            tbl_raddr = st_rdata[TA_W-1:0];
        end
        if (go) begin
            n_pc = cond_hit ? uw.tgt : fppe_pkg::t_step'(5'(r_pc) + 5'd1);
            case (uw.act)
                fppe_pkg::ACT_FILL: begin
                    tbl_we    = 1'b1;
                    tbl_waddr = r_cnt[TA_W-1:0];
                    tbl_wdata = fppe_pkg::default_val(8'(r_cnt));
                    n_cnt     = (r_cnt == CNT_W'(TABLE_ENTRIES - 1)) ? '0 : r_cnt + 1'b1;
                end
                fppe_pkg::ACT_LD_ID: begin
                    n_id  = i_rx_byte;
                    n_sum = i_rx_byte;
                end
                fppe_pkg::ACT_LD_OP: begin
                    n_op  = i_rx_byte;
                    n_sum = r_sum + i_rx_byte;
                end
                fppe_pkg::ACT_LD_LEN: begin
                    n_len = i_rx_byte[fppe_pkg::LEN_W-1:0];
                    n_sum = r_sum + i_rx_byte;
                    n_cnt = '0;
                end
                fppe_pkg::ACT_ST_PAY: begin
                    st_we = 1'b1;
                    n_sum = r_sum + i_rx_byte;
                    n_cnt = r_cnt + 1'b1;
                end
                fppe_pkg::ACT_CLR_CNT: begin
                    n_cnt = '0;
                end
                fppe_pkg::ACT_RD_INC: begin
                    n_cnt = r_cnt + 1'b1;
                end
                fppe_pkg::ACT_LD_IDX_INC: begin
                    n_idx = st_rdata;
                    n_cnt = r_cnt + 1'b1;
                end
                fppe_pkg::ACT_WR_TBL: begin
                    tbl_we = idx_ok;
                end
                fppe_pkg::ACT_CLR_SUM: begin
                    n_sum = 8'd0;
                end
                fppe_pkg::ACT_LD_IDX: begin
                    n_idx = st_rdata;
                end
                fppe_pkg::ACT_ADD_IDX: begin
                    n_sum = r_sum + r_idx;
                end
                fppe_pkg::ACT_ADD_VAL_INC: begin
                    n_sum = r_sum + tbl_val;
                    n_cnt = r_cnt + 1'b1;
                end
                default: begin
                end
            endcase
            if (uw.emit) begin
                n_tx_valid = 1'b1;
                n_tx_last  = uw.src == fppe_pkg::SRC_SUM;
                case (uw.src)
                    fppe_pkg::SRC_FF:   n_tx_byte = fppe_pkg::HDR_BYTE;
                    fppe_pkg::SRC_ID:   n_tx_byte = r_id;
                    fppe_pkg::SRC_OPRD: n_tx_byte = r_op_read;
                    fppe_pkg::SRC_LEN:  n_tx_byte = 8'(r_len);
                    fppe_pkg::SRC_IDX:  n_tx_byte = r_idx;
                    fppe_pkg::SRC_VAL:  n_tx_byte = tbl_val;
                    fppe_pkg::SRC_SUM:  n_tx_byte = r_sum;
                    default:            n_tx_byte = fppe_pkg::HDR_BYTE;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc       <= fppe_pkg::S_FILL;
            r_cnt      <= '0;
            r_tx_valid <= 1'b0;
            r_op_write <= fppe_pkg::OP_WRITE_RST;
            r_op_read  <= fppe_pkg::OP_READ_RST;
            r_op_reset <= fppe_pkg::OP_RESET_RST;
        end else begin
            r_pc       <= n_pc;
            r_cnt      <= n_cnt;
            r_tx_valid <= n_tx_valid;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    fppe_pkg::CFG_OP_WRITE: r_op_write <= i_cfg_data;
                    fppe_pkg::CFG_OP_READ:  r_op_read  <= i_cfg_data;
                    fppe_pkg::CFG_OP_RESET: r_op_reset <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_id      <= n_id;
        r_op      <= n_op;
        r_len     <= n_len;
        r_sum     <= n_sum;
        r_idx     <= n_idx;
        r_tx_byte <= n_tx_byte;
        r_tx_last <= n_tx_last;
    end

    // Received bytes are taken only in the parsing steps.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rx_ready |-> (r_pc == fppe_pkg::S_HUNT1 || r_pc == fppe_pkg::S_HUNT2 ||
                        r_pc == fppe_pkg::S_ID || r_pc == fppe_pkg::S_OPC ||
                        r_pc == fppe_pkg::S_LEN || r_pc == fppe_pkg::S_PAY ||
                        r_pc == fppe_pkg::S_CHECK))
        else $error("rx byte taken outside a parsing step");

    // Payload bytes only arrive for an accepted length inside the store.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == fppe_pkg::S_PAY) |->
            (r_len != '0 && 9'(r_len) <= 9'(MAX_PAYLOAD) && cnt_x < len_x))
        else $error("payload step with length or count out of range");

    // The fill sweep never runs past the table.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == fppe_pkg::S_FILL) |-> (9'(r_cnt) < 9'(TABLE_ENTRIES)))
        else $error("fill counter beyond the table");

    // A new closing byte of a reply comes only from the checksum step.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tx_valid && r_tx_last && !$past(r_tx_valid && r_tx_last)) |->
            $past(r_pc == fppe_pkg::S_RSUM))
        else $error("reply closing byte not issued by the checksum step");

endmodule

`default_nettype wire

[rtl/fppe_ram.sv]
// Generic simple dual-port RAM with one write port and one registered read port.
// Depends on nothing; used for the payload store and the parameter table.
`default_nettype none

module fppe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
